// ===== rtl/imh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants of the indexed min-heap
// Request and result records, command codes and register codes.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int NODE_W   = 10;
    localparam int CNT_W    = 11;
    localparam int COST_W   = 31;
    localparam int PRED_W   = 11;
    localparam int MAX_NODES = 1024;

    localparam logic [COST_W-1:0] COST_INF  = {COST_W{1'b1}};
    localparam logic [PRED_W-1:0] PRED_NONE = {PRED_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_NODES);

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_POP   = 2'd1,
        CMD_DEC   = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_NODE_COUNT = 1'b0,
        REG_START_NODE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [NODE_W-1:0]        node_id;
        logic signed [PRED_W-1:0] pred_node;
        logic [COST_W-1:0]        new_cost;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0]        out_node;
        logic [COST_W-1:0]        out_cost;
        logic signed [PRED_W-1:0] out_pred;
        logic                     valid_res;
        logic                     heap_empty;
    } res_t;

endpackage

// ===== rtl/imh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/imh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ctrl: heap sequencer with its four tables and one cost comparator
// Runs build, pop with sift down, decrease-key with sift up, and query.
// ----------------------------------------------------------------------------
module imh_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  imh_pkg::req_t               req,
    input  logic [imh_pkg::CNT_W-1:0]   node_count,
    input  logic [imh_pkg::NODE_W-1:0]  start_node,
    output logic                        res_valid,
    input  logic                        res_ready,
    output imh_pkg::res_t               res
);

    localparam int NW = imh_pkg::NODE_W;
    localparam int CW = imh_pkg::CNT_W;
    localparam int KW = imh_pkg::COST_W;
    localparam int PW = imh_pkg::PRED_W;

    typedef enum logic [21:0] {
        ST_IDLE   = 22'h000001,
        ST_FILL   = 22'h000002,
        ST_P0     = 22'h000004,
        ST_P1     = 22'h000008,
        ST_P2     = 22'h000010,
        ST_P3     = 22'h000020,
        ST_SD_L   = 22'h000040,
        ST_SD_LN  = 22'h000080,
        ST_SD_LC  = 22'h000100,
        ST_SD_RC  = 22'h000200,
        ST_SD_MV  = 22'h000400,
        ST_SD_END = 22'h000800,
        ST_DK0    = 22'h001000,
        ST_DK1    = 22'h002000,
        ST_SU     = 22'h004000,
        ST_SU_PN  = 22'h008000,
        ST_SU_PC  = 22'h010000,
        ST_SU_END = 22'h020000,
        ST_QRY    = 22'h040000,
        ST_RES    = 22'h080000,
        ST_FIN    = 22'h100000
    } state_t;

    state_t          state_reg, state_next;
    imh_pkg::req_t   req_reg;
    logic [CW-1:0]   live_reg, live_next;
    logic [CW-1:0]   built_reg, built_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [NW-1:0]   cur_reg, cur_next;
    logic [NW-1:0]   mv_node_reg, mv_node_next;
    logic [KW-1:0]   mv_cost_reg, mv_cost_next;
    logic [NW-1:0]   top_reg, top_next;
    logic [NW-1:0]   lnode_reg, lnode_next;
    logic [NW-1:0]   rnode_reg, rnode_next;
    logic [NW-1:0]   best_slot_reg, best_slot_next;
    logic [NW-1:0]   best_node_reg, best_node_next;
    logic [KW-1:0]   best_cost_reg, best_cost_next;
    imh_pkg::res_t   res_reg, res_next;

    // Table ports
    logic            s2n_we, n2s_we, cost_we, pred_we;
    logic [NW-1:0]   s2n_wa, n2s_wa, cost_wa, pred_wa;
    logic [NW-1:0]   s2n_wd, n2s_wd;
    logic [KW-1:0]   cost_wd;
    logic [PW-1:0]   pred_wd;
    logic [NW-1:0]   s2n_ra, n2s_ra, cost_ra, pred_ra;
    logic [NW-1:0]   s2n_rd, n2s_rd;
    logic [KW-1:0]   cost_rd;
    logic [PW-1:0]   pred_rd;

    // Shared comparator
    logic [KW-1:0]   cmp_a, cmp_b;
    logic            cmp_lt;

    logic [CW:0]     lchild, rchild;
    logic [NW-1:0]   parent;
    logic [CW-1:0]   n_sat;
    logic            start_in;
    logic [NW-1:0]   fill_i;

    imh_ram #(.WIDTH(NW), .DEPTH(imh_pkg::MAX_NODES)) u_s2n (
        .aclk(aclk), .we(s2n_we), .waddr(s2n_wa), .wdata(s2n_wd),
        .raddr(s2n_ra), .rdata(s2n_rd)
    );
    imh_ram #(.WIDTH(NW), .DEPTH(imh_pkg::MAX_NODES)) u_n2s (
        .aclk(aclk), .we(n2s_we), .waddr(n2s_wa), .wdata(n2s_wd),
        .raddr(n2s_ra), .rdata(n2s_rd)
    );
    imh_ram #(.WIDTH(KW), .DEPTH(imh_pkg::MAX_NODES)) u_cost (
        .aclk(aclk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
        .raddr(cost_ra), .rdata(cost_rd)
    );
    imh_ram #(.WIDTH(PW), .DEPTH(imh_pkg::MAX_NODES)) u_pred (
        .aclk(aclk), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd),
        .raddr(pred_ra), .rdata(pred_rd)
    );

    assign cmp_lt    = cmp_a < cmp_b;
    assign lchild    = {1'b0, cur_reg, 1'b1};
    assign rchild    = {1'b0, cur_reg, 1'b1} + 12'd1;
    assign parent    = NW'((cur_reg - NW'(1)) >> 1);
    assign n_sat     = (node_count > imh_pkg::CNT_MAX) ? imh_pkg::CNT_MAX : node_count;
    assign start_in  = {1'b0, start_node} < n_reg;
    assign fill_i    = cnt_reg[NW-1:0];
    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN);

    // heap_empty follows the live count, which no longer changes while the
    // result is offered, so it is valid from the first cycle of the offer.
    always_comb begin
        res            = res_reg;
        res.heap_empty = (live_reg == '0);
    end

    always_comb begin
        cmp_a = cost_rd;
        cmp_b = mv_cost_reg;
        unique case (state_reg)
            ST_SD_RC: begin
                cmp_b = best_cost_reg;
            end
            ST_SU_PC: begin
                cmp_a = mv_cost_reg;
                cmp_b = cost_rd;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        live_next      = live_reg;
        built_next     = built_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        cur_next       = cur_reg;
        mv_node_next   = mv_node_reg;
        mv_cost_next   = mv_cost_reg;
        top_next       = top_reg;
        lnode_next     = lnode_reg;
        rnode_next     = rnode_reg;
        best_slot_next = best_slot_reg;
        best_node_next = best_node_reg;
        best_cost_next = best_cost_reg;
        res_next       = res_reg;

        s2n_we = 1'b0; s2n_wa = '0; s2n_wd = '0; s2n_ra = '0;
        n2s_we = 1'b0; n2s_wa = '0; n2s_wd = '0; n2s_ra = '0;
        cost_we = 1'b0; cost_wa = '0; cost_wd = '0; cost_ra = '0;
        pred_we = 1'b0; pred_wa = '0; pred_wd = '0; pred_ra = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    res_next = '0;
                    unique case (req.cmd)
                        imh_pkg::CMD_START: begin
                            n_next     = n_sat;
                            cnt_next   = '0;
                            live_next  = n_sat;
                            built_next = n_sat;
                            state_next = (n_sat == '0) ? ST_FIN : ST_FILL;
                        end
                        imh_pkg::CMD_POP: begin
                            state_next = (live_reg == '0) ? ST_FIN : ST_P0;
                        end
                        imh_pkg::CMD_DEC: begin
                            state_next = ST_DK0;
                        end
                        default: begin
                            state_next = ST_QRY;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // Each slot holds its own node, except that the start node
                // and node zero trade places when the start node exists.
                s2n_we = 1'b1; s2n_wa = fill_i;
                n2s_we = 1'b1; n2s_wa = fill_i;
                if (start_in && fill_i == '0) begin
                    s2n_wd = start_node;
                    n2s_wd = start_node;
                end else if (start_in && fill_i == start_node) begin
                    s2n_wd = '0;
                    n2s_wd = '0;
                end else begin
                    s2n_wd = fill_i;
                    n2s_wd = fill_i;
                end
                cost_we = 1'b1; cost_wa = fill_i;
                cost_wd = (start_in && fill_i == start_node) ? '0 : imh_pkg::COST_INF;
                pred_we = 1'b1; pred_wa = fill_i; pred_wd = imh_pkg::PRED_NONE;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_next == n_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_P0: begin
                s2n_ra     = '0;
                live_next  = live_reg - CW'(1);
                state_next = ST_P1;
            end
            ST_P1: begin
                top_next   = s2n_rd;
                s2n_ra     = live_reg[NW-1:0];
                state_next = ST_P2;
            end
            ST_P2: begin
                mv_node_next = s2n_rd;
                cost_ra      = s2n_rd;
                s2n_we = 1'b1; s2n_wa = live_reg[NW-1:0]; s2n_wd = top_reg;
                n2s_we = 1'b1; n2s_wa = top_reg; n2s_wd = live_reg[NW-1:0];
                state_next   = ST_P3;
            end
            ST_P3: begin
                mv_cost_next = cost_rd;
                cur_next     = '0;
                state_next   = ST_SD_L;
            end
            ST_SD_L: begin
                s2n_ra = lchild[NW-1:0];
                state_next = (lchild >= {1'b0, live_reg}) ? ST_SD_END : ST_SD_LN;
            end
            ST_SD_LN: begin
                lnode_next = s2n_rd;
                cost_ra    = s2n_rd;
                s2n_ra     = rchild[NW-1:0];
                state_next = ST_SD_LC;
            end
            ST_SD_LC: begin
                rnode_next = s2n_rd;
                if (cmp_lt) begin
                    best_slot_next = lchild[NW-1:0];
                    best_node_next = lnode_reg;
                    best_cost_next = cost_rd;
                end else begin
                    best_slot_next = cur_reg;
                    best_node_next = mv_node_reg;
                    best_cost_next = mv_cost_reg;
                end
                cost_ra = s2n_rd;
                state_next = (rchild < {1'b0, live_reg}) ? ST_SD_RC : ST_SD_MV;
            end
            ST_SD_RC: begin
                if (cmp_lt) begin
                    best_slot_next = rchild[NW-1:0];
                    best_node_next = rnode_reg;
                    best_cost_next = cost_rd;
                end
                state_next = ST_SD_MV;
            end
            ST_SD_MV: begin
                if (best_slot_reg == cur_reg) begin
                    state_next = ST_SD_END;
                end else begin
                    // The smaller child moves up into the hole.
                    s2n_we = 1'b1; s2n_wa = cur_reg; s2n_wd = best_node_reg;
                    n2s_we = 1'b1; n2s_wa = best_node_reg; n2s_wd = cur_reg;
                    cur_next   = best_slot_reg;
                    state_next = ST_SD_L;
                end
            end
            ST_SD_END: begin
                s2n_we = 1'b1; s2n_wa = cur_reg; s2n_wd = mv_node_reg;
                n2s_we = 1'b1; n2s_wa = mv_node_reg; n2s_wd = cur_reg;
                cost_ra = top_reg;
                pred_ra = top_reg;
                res_next.out_node  = top_reg;
                res_next.valid_res = 1'b1;
                state_next = ST_RES;
            end
            ST_DK0: begin
                if ({1'b0, req_reg.node_id} >= built_reg) begin
                    state_next = ST_FIN;
                end else begin
                    n2s_ra = req_reg.node_id;
                    cost_we = 1'b1; cost_wa = req_reg.node_id; cost_wd = req_reg.new_cost;
                    pred_we = 1'b1; pred_wa = req_reg.node_id;
                    pred_wd = PW'(req_reg.pred_node);
                    state_next = ST_DK1;
                end
            end
            ST_DK1: begin
                cur_next     = n2s_rd;
                mv_node_next = req_reg.node_id;
                mv_cost_next = req_reg.new_cost;
                state_next   = ({1'b0, n2s_rd} < live_reg) ? ST_SU : ST_FIN;
            end
            ST_SU: begin
                s2n_ra     = parent;
                state_next = (cur_reg == '0) ? ST_SU_END : ST_SU_PN;
            end
            ST_SU_PN: begin
                lnode_next = s2n_rd;
                cost_ra    = s2n_rd;
                state_next = ST_SU_PC;
            end
            ST_SU_PC: begin
                if (cmp_lt) begin
                    // Parent is dearer: it moves down into the hole.
                    s2n_we = 1'b1; s2n_wa = cur_reg; s2n_wd = lnode_reg;
                    n2s_we = 1'b1; n2s_wa = lnode_reg; n2s_wd = cur_reg;
                    cur_next   = parent;
                    state_next = ST_SU;
                end else begin
                    state_next = ST_SU_END;
                end
            end
            ST_SU_END: begin
                s2n_we = 1'b1; s2n_wa = cur_reg; s2n_wd = mv_node_reg;
                n2s_we = 1'b1; n2s_wa = mv_node_reg; n2s_wd = cur_reg;
                state_next = ST_FIN;
            end
            ST_QRY: begin
                if ({1'b0, req_reg.node_id} >= built_reg) begin
                    state_next = ST_FIN;
                end else begin
                    cost_ra = req_reg.node_id;
                    pred_ra = req_reg.node_id;
                    res_next.out_node  = req_reg.node_id;
                    res_next.valid_res = 1'b1;
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                res_next.out_cost = cost_rd;
                res_next.out_pred = pred_rd;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            live_reg  <= '0;
            built_reg <= '0;
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            built_reg <= built_next;
        end
        if (state_reg == ST_IDLE && req_valid) begin
            req_reg <= req;
        end
        cnt_reg       <= cnt_next;
        n_reg         <= n_next;
        cur_reg       <= cur_next;
        mv_node_reg   <= mv_node_next;
        mv_cost_reg   <= mv_cost_next;
        top_reg       <= top_next;
        lnode_reg     <= lnode_next;
        rnode_reg     <= rnode_next;
        best_slot_reg <= best_slot_next;
        best_node_reg <= best_node_next;
        best_cost_reg <= best_cost_next;
        res_reg       <= res_next;
    end

endmodule

// ===== rtl/indexed_min_heap_decrease_key.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key: indexed binary min-heap for path searches
// Stream request in, stream result out, APB register port for setup.
// ----------------------------------------------------------------------------
// This block keeps an indexed binary min-heap of up to 1024 graph nodes keyed
// by path cost. Every request gives exactly one result. A start request
// fills the heap with node_count nodes at cost 2147483647 and no predecessor
// and puts start_node at the top with cost zero when start_node is below
// node_count; it writes one table row per cycle. A pop request returns the
// cheapest node and sifts the heap down, at a pace set by the single read
// port of each table and the one shared cost comparator. A decrease-key
// request sifts its node up. The block takes one request at a time; it holds
// its result in an output register until the sink takes it. Table entries
// past the last start are not cleared, and requests naming such nodes answer
// with valid_res low.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // node_id[9:0], pred_node[20:10], new_cost[51:21]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // out_node[9:0], out_cost[40:10], out_pred[51:41]
    output logic [1:0]  m_axis_tuser,  // valid_res[0], heap_empty[1]
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [imh_pkg::CNT_W-1:0]  node_count_reg;
    logic [imh_pkg::NODE_W-1:0] start_node_reg;
    imh_pkg::req_t              req;
    imh_pkg::res_t              res;
    logic                       res_valid;
    logic                       res_ready;
    logic                       out_valid_reg;
    imh_pkg::res_t              out_reg;
    imh_pkg::reg_idx_t          reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = imh_pkg::reg_idx_t'(paddr[2]);

    // Register writes land on the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= imh_pkg::CNT_MAX;
            start_node_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                imh_pkg::REG_NODE_COUNT: node_count_reg <= pwdata[imh_pkg::CNT_W-1:0];
                imh_pkg::REG_START_NODE: start_node_reg <= pwdata[imh_pkg::NODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            imh_pkg::REG_NODE_COUNT: prdata = 32'(node_count_reg);
            imh_pkg::REG_START_NODE: prdata = 32'(start_node_reg);
            default:                 prdata = '0;
        endcase
    end

    assign req.cmd       = imh_pkg::cmd_t'(s_axis_tuser);
    assign req.node_id   = s_axis_tdata[9:0];
    assign req.pred_node = s_axis_tdata[20:10];
    assign req.new_cost  = s_axis_tdata[51:21];

    imh_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req        (req),
        .node_count (node_count_reg),
        .start_node (start_node_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: the sequencer hands over a result whenever the
    // register is empty or is being emptied in the same cycle.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.out_pred, out_reg.out_cost, out_reg.out_node};
    assign m_axis_tuser  = {out_reg.heap_empty, out_reg.valid_res};

endmodule
